// ===== rtl/core/evs_pkg.sv =====
// ----------------------------------------------------------------------------
// evs_pkg
// Shared types and constants for the eviction victim selector.
// ----------------------------------------------------------------------------
package evs_pkg;

    localparam int ID_W   = 32;
    localparam int PRI_W  = 16;
    localparam int TIME_W = 32;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_EVICT_BY_PRIORITY = 2'd0;
    localparam t_cfg_idx CFG_EVICT_BY_AGE      = 2'd1;
    localparam t_cfg_idx CFG_AGE_THRESHOLD     = 2'd2;

    localparam logic [TIME_W-1:0] AGE_THRESHOLD_RST = 32'd300;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_evs_state;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic shift;
        logic finish;
    } t_evs_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic pend_vld;
        logic vcnt_last;
        logic out_free;
    } t_evs_sts;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] queued;
        logic              preserved;
        logic [TIME_W-1:0] expiry;
    } t_evs_entry;

endpackage

// ===== rtl/core/evs_ctrl.sv =====
// ----------------------------------------------------------------------------
// evs_ctrl
// Sequencer: loads entries, runs one store scan per victim, and hands each
// victim to the output register one scan behind so the final one is marked.
// ----------------------------------------------------------------------------
module evs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_last_entry,
    input  evs_pkg::t_evs_sts i_sts,
    output evs_pkg::t_evs_cmd o_cmd,
    output logic              o_stall
);
    import evs_pkg::*;

    t_evs_state r_state;
    t_evs_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_valid && i_last_entry) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.found ? S_SHIFT : S_FINISH;
                end
            end
            S_SHIFT: begin
                if (!i_sts.pend_vld || i_sts.out_free) begin
                    n_state = i_sts.vcnt_last ? S_FINISH : S_SCAN;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_LOAD: begin
                o_stall         = 1'b0;
                o_cmd.load      = i_valid;
                o_cmd.scan_init = i_valid && i_last_entry;
            end
            S_SCAN: begin
            end
            S_SHIFT: begin
                if (!i_sts.pend_vld || i_sts.out_free) begin
                    o_cmd.shift     = 1'b1;
                    o_cmd.scan_init = !i_sts.vcnt_last;
                end
            end
            S_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/evs_datapath.sv =====
// ----------------------------------------------------------------------------
// evs_datapath
// Entry store, configuration registers, scan unit with best-candidate
// registers, pending victim and the output register.
// ----------------------------------------------------------------------------
module evs_datapath #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_VICTIMS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  evs_pkg::t_evs_cmd            i_cmd,
    output evs_pkg::t_evs_sts            o_sts,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  evs_pkg::t_cfg_idx            i_cfg_index,
    input  logic [evs_pkg::TIME_W-1:0]   i_cfg_data,
    input  logic [evs_pkg::ID_W-1:0]     i_entry_id,
    input  logic [evs_pkg::PRI_W-1:0]    i_priority_req,
    input  logic [evs_pkg::TIME_W-1:0]   i_queued_at,
    input  logic                         i_is_preserved,
    input  logic [evs_pkg::TIME_W-1:0]   i_preserve_until,
    input  logic [evs_pkg::TIME_W-1:0]   i_now_time,
    input  logic                         i_last_entry,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [evs_pkg::ID_W-1:0]     o_victim_id,
    output logic                         o_none_found,
    output logic                         o_overflowed,
    output logic                         o_last_victim
);
    import evs_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int VC_W  = $clog2(MAX_VICTIMS + 1);

    t_evs_entry r_mem [QUEUE_DEPTH];
    t_evs_entry r_rd_data;

    logic              r_by_prio;
    logic              r_by_age;
    logic [TIME_W-1:0] r_age_thr;

    logic [CNT_W-1:0]       r_cnt;
    logic                   r_ovf;
    logic [TIME_W-1:0]      r_now;
    logic [QUEUE_DEPTH-1:0] r_picked;

    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_scan_act;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_fnd;
    logic [IDX_W-1:0]  r_best_idx;
    logic [TIME_W-1:0] r_best_key;
    logic [ID_W-1:0]   r_best_id;

    logic              r_pnd_vld;
    logic [ID_W-1:0]   r_pnd_id;
    logic [VC_W-1:0]   r_vcnt;

    logic              r_out_vld;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_none;
    logic              r_out_ovf;
    logic              r_out_last;

    logic              store_wr;
    logic              rd_more;
    logic [TIME_W-1:0] pri_key;
    logic [TIME_W-1:0] age;
    logic              qual;
    logic              better;
    logic [TIME_W-1:0] cand_key;
    logic              upd;
    logic              out_free;
    logic              emit_prev;
    t_evs_entry        wr_entry;

    assign o_cfg_ready = 1'b1;
    assign store_wr    = i_cmd.load && (r_cnt < CNT_W'(QUEUE_DEPTH));
    assign rd_more     = r_rd_idx < r_cnt;
    assign out_free    = !r_out_vld || !i_stall;
    assign emit_prev   = i_cmd.shift && r_pnd_vld;

    assign wr_entry.id        = i_entry_id;
    assign wr_entry.pri       = i_priority_req;
    assign wr_entry.queued    = i_queued_at;
    assign wr_entry.preserved = i_is_preserved;
    assign wr_entry.expiry    = i_preserve_until;

    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_mem[r_cnt[IDX_W-1:0]] <= wr_entry;
        end
        r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
    end

    always_comb begin
        pri_key  = {{(TIME_W-PRI_W){1'b0}}, r_rd_data.pri};
        age      = r_now - r_rd_data.queued;
        qual     = 1'b0;
        better   = 1'b0;
        cand_key = pri_key;
        if (r_by_prio) begin
            qual   = 1'b1;
            better = !r_fnd || (pri_key < r_best_key);
        end else if (r_by_age) begin
            cand_key = age;
            qual     = age > r_age_thr;
            better   = !r_fnd || (age > r_best_key);
        end else begin
            qual   = !r_rd_data.preserved || (r_now > r_rd_data.expiry);
            better = !r_fnd;
        end
        upd = r_cmp_vld && !r_picked[r_cmp_idx] && qual && better;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_by_prio  <= 1'b1;
            r_by_age   <= 1'b1;
            r_age_thr  <= AGE_THRESHOLD_RST;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_picked   <= '0;
            r_rd_idx   <= '0;
            r_scan_act <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_fnd      <= 1'b0;
            r_pnd_vld  <= 1'b0;
            r_vcnt     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_EVICT_BY_PRIORITY: r_by_prio <= i_cfg_data[0];
                    CFG_EVICT_BY_AGE:      r_by_age  <= i_cfg_data[0];
                    CFG_AGE_THRESHOLD:     r_age_thr <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (store_wr) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.load) begin
                r_ovf <= 1'b1;
            end

            if (i_cmd.scan_init) begin
                r_rd_idx   <= '0;
                r_scan_act <= 1'b1;
                r_cmp_vld  <= 1'b0;
                r_fnd      <= 1'b0;
            end else if (r_scan_act) begin
                r_cmp_vld <= rd_more;
                if (rd_more) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end else if (!r_cmp_vld) begin
                    r_scan_act <= 1'b0;
                end
                if (upd) begin
                    r_fnd <= 1'b1;
                end
            end

            if (i_cmd.shift) begin
                r_picked[r_best_idx] <= 1'b1;
                r_pnd_vld            <= 1'b1;
                r_vcnt               <= r_vcnt + VC_W'(1);
            end

            if (emit_prev || i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end

            if (i_cmd.finish) begin
                r_cnt     <= '0;
                r_ovf     <= 1'b0;
                r_picked  <= '0;
                r_pnd_vld <= 1'b0;
                r_vcnt    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_last_entry) begin
            r_now <= i_now_time;
        end
        r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        if (upd) begin
            r_best_idx <= r_cmp_idx;
            r_best_key <= cand_key;
            r_best_id  <= r_rd_data.id;
        end
        if (i_cmd.shift) begin
            r_pnd_id <= r_best_id;
        end
        if (emit_prev) begin
            r_out_id   <= r_pnd_id;
            r_out_none <= 1'b0;
            r_out_ovf  <= r_ovf;
            r_out_last <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_id   <= r_pnd_vld ? r_pnd_id : '0;
            r_out_none <= !r_pnd_vld;
            r_out_ovf  <= r_ovf;
            r_out_last <= 1'b1;
        end
    end

    assign o_sts.scan_done = r_scan_act && !rd_more && !r_cmp_vld;
    assign o_sts.found     = r_fnd;
    assign o_sts.pend_vld  = r_pnd_vld;
    assign o_sts.vcnt_last = r_vcnt == VC_W'(MAX_VICTIMS - 1);
    assign o_sts.out_free  = out_free;

    assign o_valid       = r_out_vld;
    assign o_victim_id   = r_out_id;
    assign o_none_found  = r_out_none;
    assign o_overflowed  = r_out_ovf;
    assign o_last_victim = r_out_last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds store depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_prev || i_cmd.finish) |-> out_free)
        else $error("result written over an unaccepted result");

    a_pick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_picked) <= MAX_VICTIMS)
        else $error("more entries picked than victims allowed");

    a_none_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_none) |-> (r_out_last && (r_out_id == '0)))
        else $error("empty result is malformed");
`endif

endmodule

// ===== rtl/core/eviction_victim_selector_core.sv =====
// ----------------------------------------------------------------------------
// eviction_victim_selector_core
// Entries load at one request per cycle into a store of QUEUE_DEPTH entries;
// extra entries are dropped and flagged. The request marked last closes the
// batch and starts selection, during which the input is stalled. Each victim
// costs one pass over the store through its single read port, plus a step to
// hand it on; when fewer than MAX_VICTIMS entries qualify, a final pass finds
// none. The input stall also lasts while the output is stalled. Victims leave
// one pass behind their selection so the final one can be marked. The last
// result may still wait in the output register while the next batch loads.
// ----------------------------------------------------------------------------
module eviction_victim_selector_core #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_VICTIMS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  evs_pkg::t_cfg_idx            i_cfg_index,
    input  logic [evs_pkg::TIME_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [evs_pkg::ID_W-1:0]     i_entry_id,
    input  logic [evs_pkg::PRI_W-1:0]    i_priority_req,
    input  logic [evs_pkg::TIME_W-1:0]   i_queued_at,
    input  logic                         i_is_preserved,
    input  logic [evs_pkg::TIME_W-1:0]   i_preserve_until,
    input  logic [evs_pkg::TIME_W-1:0]   i_now_time,
    input  logic                         i_last_entry,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [evs_pkg::ID_W-1:0]     o_victim_id,
    output logic                         o_none_found,
    output logic                         o_overflowed,
    output logic                         o_last_victim
);
    import evs_pkg::*;

    t_evs_cmd cmd;
    t_evs_sts sts;

    evs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_entry (i_last_entry),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_stall      (o_stall)
    );

    evs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_VICTIMS (MAX_VICTIMS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_entry_id       (i_entry_id),
        .i_priority_req   (i_priority_req),
        .i_queued_at      (i_queued_at),
        .i_is_preserved   (i_is_preserved),
        .i_preserve_until (i_preserve_until),
        .i_now_time       (i_now_time),
        .i_last_entry     (i_last_entry),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_victim_id      (o_victim_id),
        .o_none_found     (o_none_found),
        .o_overflowed     (o_overflowed),
        .o_last_victim    (o_last_victim)
    );

endmodule
